@@ sv/pid_axis_controller_defines.svh @@
// Assertion macros for the PID axis controller.
`ifndef PID_AXIS_CONTROLLER_DEFINES_SVH
`define PID_AXIS_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pac_pkg.sv @@
// Types, constants and microcode ROM for the PID axis controller.
`timescale 1ns / 1ps
`default_nettype none
package pac_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned ACC_W     = 35;
  localparam int unsigned ALU_W     = 36;
  localparam int unsigned PC_W      = 4;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ADDR_W    = REG_IDX_W + 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SP_WEIGHT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_DEC  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_GAIN = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_OFFSET = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MIN    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MAX    = 3'd7;

  // limit status codes
  localparam logic [1:0] LIM_NONE = 2'd0;
  localparam logic [1:0] LIM_MIN  = 2'd1;
  localparam logic [1:0] LIM_MAX  = 2'd2;

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {MA_SW, MA_BD, MA_K, MA_AD, MA_KI} mul_a_e;
  typedef enum logic [1:0] {MB_R, MB_TA, MB_D} mul_b_e;
  typedef enum logic [1:0] {AX_M, AX_Y, AX_R, AX_ACC} alu_x_e;
  typedef enum logic [2:0] {
    AY_ZERO, AY_Y, AY_PREV, AY_TB, AY_INTEG, AY_D, AY_OFFSET
  } alu_y_e;
  typedef enum logic [2:0] {
    DST_NONE, DST_TA, DST_TB, DST_D, DST_ACC, DST_INTEG
  } alu_dst_e;
  typedef enum logic [1:0] {JMP_NEXT, JMP_DONE_KI0, JMP_DONE} jmp_e;

  typedef struct packed {
    mul_a_e   mul_a;
    mul_b_e   mul_b;
    alu_x_e   alu_x;
    alu_y_e   alu_y;
    logic     alu_sub;
    alu_dst_e dst;
    logic     emit;     // form drive, load output, latch prev measurement
    jmp_e     jmp;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   en;    // step executes this cycle
    logic   load;  // request accepted, capture r and y
  } dp_ctrl_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] setpoint_weight;
    logic signed [DATA_W-1:0] deriv_decay;
    logic signed [DATA_W-1:0] deriv_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] out_offset;
    logic signed [DATA_W-1:0] out_min;
    logic signed [DATA_W-1:0] out_max;
  } cfg_t;

  // Program. M is the scaled, saturated product of the previous step.
  function automatic ucode_t pac_ucode(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '{mul_a: MA_SW, mul_b: MB_R, alu_x: AX_M, alu_y: AY_ZERO, alu_sub: 1'b0,
           dst: DST_NONE, emit: 1'b0, jmp: JMP_DONE};
    case (pc)
      // dy = y - prev ; mul b*r
      4'd0: uc = '{mul_a: MA_SW, mul_b: MB_R, alu_x: AX_Y, alu_y: AY_PREV,
                   alu_sub: 1'b1, dst: DST_TA, emit: 1'b0, jmp: JMP_NEXT};
      // perr = M - y ; mul bd*dy
      4'd1: uc = '{mul_a: MA_BD, mul_b: MB_TA, alu_x: AX_M, alu_y: AY_Y,
                   alu_sub: 1'b1, dst: DST_TA, emit: 1'b0, jmp: JMP_NEXT};
      // tb = bd*dy ; mul K*perr
      4'd2: uc = '{mul_a: MA_K, mul_b: MB_TA, alu_x: AX_M, alu_y: AY_ZERO,
                   alu_sub: 1'b0, dst: DST_TB, emit: 1'b0, jmp: JMP_NEXT};
      // acc = P + I ; mul ad*D
      4'd3: uc = '{mul_a: MA_AD, mul_b: MB_D, alu_x: AX_M, alu_y: AY_INTEG,
                   alu_sub: 1'b0, dst: DST_ACC, emit: 1'b0, jmp: JMP_NEXT};
      // D = ad*D - bd*dy
      4'd4: uc = '{mul_a: MA_SW, mul_b: MB_R, alu_x: AX_M, alu_y: AY_TB,
                   alu_sub: 1'b1, dst: DST_D, emit: 1'b0, jmp: JMP_NEXT};
      // acc += D
      4'd5: uc = '{mul_a: MA_SW, mul_b: MB_R, alu_x: AX_ACC, alu_y: AY_D,
                   alu_sub: 1'b0, dst: DST_ACC, emit: 1'b0, jmp: JMP_NEXT};
      // acc += offset
      4'd6: uc = '{mul_a: MA_SW, mul_b: MB_R, alu_x: AX_ACC, alu_y: AY_OFFSET,
                   alu_sub: 1'b0, dst: DST_ACC, emit: 1'b0, jmp: JMP_NEXT};
      // emit drive ; ierr = r - y ; finish if ki is zero
      4'd7: uc = '{mul_a: MA_SW, mul_b: MB_R, alu_x: AX_R, alu_y: AY_Y,
                   alu_sub: 1'b1, dst: DST_TA, emit: 1'b1, jmp: JMP_DONE_KI0};
      // mul ki*ierr
      4'd8: uc = '{mul_a: MA_KI, mul_b: MB_TA, alu_x: AX_M, alu_y: AY_ZERO,
                   alu_sub: 1'b0, dst: DST_NONE, emit: 1'b0, jmp: JMP_NEXT};
      // I += ki*ierr
      4'd9: uc = '{mul_a: MA_SW, mul_b: MB_R, alu_x: AX_M, alu_y: AY_INTEG,
                   alu_sub: 1'b0, dst: DST_INTEG, emit: 1'b0, jmp: JMP_DONE};
      default: ;
    endcase
    return uc;
  endfunction

endpackage
`default_nettype wire

@@ sv/pid_axis_controller.sv @@
// Top level of the PID axis controller: register port, sequencer, datapath.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   input    | in_valid_i / in_stall_o  | setpoint_i, measurement_i
//   output   | out_valid_o / out_stall_i| drive_o, limit_status_o
//   config   | psel/penable/pwrite      | paddr, pwdata, prdata
//
// A request runs the accept plus 8 microcode steps when integ_gain is zero,
// plus the integrator steps when it is not, on one shared 32x32
// multiplier and one saturating adder.
// The drive is loaded into the output register at step 7; the integrator
// update follows after it.
// Reset clears the handshake, the integrator, the derivative filter and the
// previous measurement, and loads the configuration registers with their defaults.
// A stalled result holds the program at its result step; no new request is
// taken while a program runs.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_axis_controller_defines.svh"
module pid_axis_controller #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [pac_pkg::DATA_W-1:0] setpoint_i,
  input  wire logic signed [pac_pkg::DATA_W-1:0] measurement_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [pac_pkg::DATA_W-1:0]      drive_o,
  output logic [1:0]                             limit_status_o,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pac_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [pac_pkg::DATA_W-1:0]        pwdata,
  output logic [pac_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready
);
  import pac_pkg::*;

  // 1.0 in the chosen fixed-point format
  localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

  cfg_t                 cfg_q;
  dp_ctrl_t             ctrl;
  logic                 ki_zero;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= ONE_FX;
      cfg_q.setpoint_weight <= ONE_FX;
      cfg_q.deriv_decay     <= '0;
      cfg_q.deriv_gain      <= '0;
      cfg_q.integ_gain      <= '0;
      cfg_q.out_offset      <= '0;
      cfg_q.out_min         <= S32_MIN;
      cfg_q.out_max         <= S32_MAX;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PROP_GAIN:  cfg_q.prop_gain       <= pwdata;
        REG_SP_WEIGHT:  cfg_q.setpoint_weight <= pwdata;
        REG_DERIV_DEC:  cfg_q.deriv_decay     <= pwdata;
        REG_DERIV_GAIN: cfg_q.deriv_gain      <= pwdata;
        REG_INTEG_GAIN: cfg_q.integ_gain      <= pwdata;
        REG_OUT_OFFSET: cfg_q.out_offset      <= pwdata;
        REG_OUT_MIN:    cfg_q.out_min         <= pwdata;
        REG_OUT_MAX:    cfg_q.out_max         <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_PROP_GAIN:  prdata = cfg_q.prop_gain;
      REG_SP_WEIGHT:  prdata = cfg_q.setpoint_weight;
      REG_DERIV_DEC:  prdata = cfg_q.deriv_decay;
      REG_DERIV_GAIN: prdata = cfg_q.deriv_gain;
      REG_INTEG_GAIN: prdata = cfg_q.integ_gain;
      REG_OUT_OFFSET: prdata = cfg_q.out_offset;
      REG_OUT_MIN:    prdata = cfg_q.out_min;
      REG_OUT_MAX:    prdata = cfg_q.out_max;
      default:        prdata = '0;
    endcase
  end

  // step counter and microcode ROM
  pac_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .ki_zero_i   (ki_zero),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  // shared multiplier, adder and loop state
  pac_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_i          (cfg_q),
    .setpoint_i     (setpoint_i),
    .measurement_i  (measurement_i),
    .drive_o        (drive_o),
    .limit_status_o (limit_status_o),
    .ki_zero_o      (ki_zero)
  );

  // a new request always starts a program that keeps the input stalled
  `PAC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no busy after accept")
  // max clamp reports the configured upper bound
  `PAC_ASSERT_NOW(a_max_clamp, out_valid_o && (limit_status_o == LIM_MAX), drive_o == cfg_q.out_max, "max clamp mismatch")
  // min clamp reports the configured lower bound
  `PAC_ASSERT_NOW(a_min_clamp, out_valid_o && (limit_status_o == LIM_MIN), drive_o == cfg_q.out_min, "min clamp mismatch")
  // unclamped drive lies within the limits
  `PAC_ASSERT_NOW(a_in_range, out_valid_o && (limit_status_o == LIM_NONE), (drive_o >= cfg_q.out_min) && (drive_o <= cfg_q.out_max), "drive out of range")

endmodule
`default_nettype wire

@@ sv/pac_sequencer.sv @@
// Step counter, microcode fetch and handshake control.
`timescale 1ns / 1ps
`default_nettype none
module pac_sequencer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic              ki_zero_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output pac_pkg::dp_ctrl_t      ctrl_o
);
  import pac_pkg::*;

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            out_valid_q, out_valid_d;
  ucode_t          uc;
  logic            hold, en, accept, done;

  assign uc     = pac_ucode(pc_q);
  // result step waits while the previous result is still stalled
  assign hold   = uc.emit && out_valid_q && out_stall_i;
  assign en     = busy_q && !hold;
  assign accept = in_valid_i && !busy_q;
  assign done   = en && ((uc.jmp == JMP_DONE) ||
                         ((uc.jmp == JMP_DONE_KI0) && ki_zero_i));

  always_comb begin
    pc_d        = pc_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      pc_d   = '0;
      busy_d = 1'b1;
    end else if (en) begin
      pc_d = pc_q + PC_W'(1);
      if (done) begin
        busy_d = 1'b0;
      end
    end
    if (en && uc.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign ctrl_o      = '{uc: uc, en: en, load: accept};

endmodule
`default_nettype wire

@@ sv/pac_datapath.sv @@
// Shared multiplier, saturating adder, state and output registers.
`timescale 1ns / 1ps
`default_nettype none
module pac_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pac_pkg::dp_ctrl_t             ctrl_i,
  input  wire pac_pkg::cfg_t                 cfg_i,
  input  wire logic signed [pac_pkg::DATA_W-1:0] setpoint_i,
  input  wire logic signed [pac_pkg::DATA_W-1:0] measurement_i,
  output logic signed [pac_pkg::DATA_W-1:0]  drive_o,
  output logic [1:0]                         limit_status_o,
  output logic                               ki_zero_o
);
  import pac_pkg::*;

  logic signed [DATA_W-1:0] r_q, y_q, ta_q, tb_q, d_q, integ_q, prev_q;
  logic signed [DATA_W-1:0] drive_q;
  logic [1:0]               status_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [DATA_W-1:0] mul_a, mul_b, mres, sum_sat, acc_sat;
  logic signed [PROD_W-1:0] shifted;
  logic signed [ALU_W-1:0]  alu_x, alu_y, sum;
  logic signed [DATA_W-1:0] drive_d;
  logic [1:0]               status_d;

  // multiplier operands
  always_comb begin
    case (ctrl_i.uc.mul_a)
      MA_SW:   mul_a = cfg_i.setpoint_weight;
      MA_BD:   mul_a = cfg_i.deriv_gain;
      MA_K:    mul_a = cfg_i.prop_gain;
      MA_AD:   mul_a = cfg_i.deriv_decay;
      MA_KI:   mul_a = cfg_i.integ_gain;
      default: mul_a = cfg_i.setpoint_weight;
    endcase
    case (ctrl_i.uc.mul_b)
      MB_R:    mul_b = r_q;
      MB_TA:   mul_b = ta_q;
      MB_D:    mul_b = d_q;
      default: mul_b = r_q;
    endcase
  end

  // floor shift, then saturate to 32 bits
  assign shifted = prod_q >>> FRAC_BITS;
  always_comb begin
    if ((&shifted[PROD_W-1:DATA_W-1]) || !(|shifted[PROD_W-1:DATA_W-1])) begin
      mres = shifted[DATA_W-1:0];
    end else begin
      mres = shifted[PROD_W-1] ? S32_MIN : S32_MAX;
    end
  end

  always_comb begin
    case (ctrl_i.uc.alu_x)
      AX_M:    alu_x = ALU_W'(mres);
      AX_Y:    alu_x = ALU_W'(y_q);
      AX_R:    alu_x = ALU_W'(r_q);
      AX_ACC:  alu_x = ALU_W'(acc_q);
      default: alu_x = ALU_W'(mres);
    endcase
    case (ctrl_i.uc.alu_y)
      AY_ZERO:   alu_y = '0;
      AY_Y:      alu_y = ALU_W'(y_q);
      AY_PREV:   alu_y = ALU_W'(prev_q);
      AY_TB:     alu_y = ALU_W'(tb_q);
      AY_INTEG:  alu_y = ALU_W'(integ_q);
      AY_D:      alu_y = ALU_W'(d_q);
      AY_OFFSET: alu_y = ALU_W'(cfg_i.out_offset);
      default:   alu_y = '0;
    endcase
  end

  assign sum = ctrl_i.uc.alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);

  always_comb begin
    if ((&sum[ALU_W-1:DATA_W-1]) || !(|sum[ALU_W-1:DATA_W-1])) begin
      sum_sat = sum[DATA_W-1:0];
    end else begin
      sum_sat = sum[ALU_W-1] ? S32_MIN : S32_MAX;
    end
    if ((&acc_q[ACC_W-1:DATA_W-1]) || !(|acc_q[ACC_W-1:DATA_W-1])) begin
      acc_sat = acc_q[DATA_W-1:0];
    end else begin
      acc_sat = acc_q[ACC_W-1] ? S32_MIN : S32_MAX;
    end
  end

  // clamp: minimum first, then maximum
  always_comb begin
    drive_d  = acc_sat;
    status_d = LIM_NONE;
    if (acc_sat < cfg_i.out_min) begin
      drive_d  = cfg_i.out_min;
      status_d = LIM_MIN;
    end else if (acc_sat > cfg_i.out_max) begin
      drive_d  = cfg_i.out_max;
      status_d = LIM_MAX;
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      d_q     <= '0;
      prev_q  <= '0;
    end else if (ctrl_i.en) begin
      if (ctrl_i.uc.dst == DST_INTEG) begin
        integ_q <= sum_sat;
      end
      if (ctrl_i.uc.dst == DST_D) begin
        d_q <= sum_sat;
      end
      if (ctrl_i.uc.emit) begin
        prev_q <= y_q;
      end
    end
  end

  // scratch and output registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      r_q <= setpoint_i;
      y_q <= measurement_i;
    end
    if (ctrl_i.en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (ctrl_i.uc.dst == DST_TA) begin
        ta_q <= sum_sat;
      end
      if (ctrl_i.uc.dst == DST_TB) begin
        tb_q <= sum_sat;
      end
      if (ctrl_i.uc.dst == DST_ACC) begin
        acc_q <= sum[ACC_W-1:0];
      end
      if (ctrl_i.uc.emit) begin
        drive_q  <= drive_d;
        status_q <= status_d;
      end
    end
  end

  assign drive_o        = drive_q;
  assign limit_status_o = status_q;
  assign ki_zero_o      = (cfg_i.integ_gain == '0);

endmodule
`default_nettype wire

@@ dv/pid_axis_controller_test.sv @@
// Self-checking testbench for the PID axis controller: drive prediction and compare.
`timescale 1ns / 1ps
module pid_axis_controller_test;
  import pac_pkg::*;

  localparam int unsigned FRAC          = 16;
  localparam int unsigned SETTLE_CYCLES = 24;      // covers the integrator steps after emit
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned BLOCK_ITEMS   = 95;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef struct packed {
    word_t      drive;
    logic [1:0] status;
  } drive_res_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  word_t             setpoint_i    = '0;
  word_t             measurement_i = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  word_t             drive_o;
  logic [1:0]        limit_status_o;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor copy of registers and loop state
  cfg_t  gains;
  word_t integ_acc  = '0;
  word_t deriv_acc  = '0;
  word_t last_meas  = '0;

  drive_res_t  expected_drives[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  logic        hold_on        = 1'b0;

  pid_axis_controller #(
    .FRAC_BITS(FRAC)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .drive_o       (drive_o),
    .limit_status_o(limit_status_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side stall: random idling plus the long hold-off
  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    drive_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drives.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: drive %h status %0d", drive_o, limit_status_o);
      end else begin
        want = expected_drives.pop_front();
        if (drive_o !== want.drive || limit_status_o !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: drive exp %h got %h, status exp %0d got %0d",
                     want.drive, drive_o, want.status, limit_status_o);
        end
      end
    end
  end

  function automatic word_t sat_word(input logic signed [63:0] v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic word_t sat_sub(input logic signed [63:0] a, input logic signed [63:0] c);
    return sat_word(a - c);
  endfunction

  // exact 64-bit product, floor shift, saturate
  function automatic word_t q_mul(input word_t a, input word_t c);
    logic signed [63:0] prod;
    prod = a * c;
    return sat_word(prod >>> FRAC);
  endfunction

  // one sample of the control law; advances the predictor state
  function automatic drive_res_t predict_drive(input word_t r, input word_t y);
    word_t              k, b, ad, bd, ki, ofs, lo, hi, pterm, dy, ierr;
    logic signed [63:0] total;
    drive_res_t         res;
    k   = gains.prop_gain;
    b   = gains.setpoint_weight;
    ad  = gains.deriv_decay;
    bd  = gains.deriv_gain;
    ki  = gains.integ_gain;
    ofs = gains.out_offset;
    lo  = gains.out_min;
    hi  = gains.out_max;

    pterm     = q_mul(k, sat_sub(q_mul(b, r), y));
    dy        = sat_sub(y, last_meas);
    deriv_acc = sat_sub(q_mul(ad, deriv_acc), q_mul(bd, dy));

    total = pterm;
    total = total + integ_acc;
    total = total + deriv_acc;
    total = total + ofs;
    res.drive  = sat_word(total);
    res.status = LIM_NONE;
    if (res.drive < lo) begin
      res.drive  = lo;
      res.status = LIM_MIN;
    end else if (res.drive > hi) begin
      res.drive  = hi;
      res.status = LIM_MAX;
    end

    // zero integral gain holds the integrator
    if (ki != 0) begin
      ierr  = sat_sub(r, y);
      total = integ_acc;
      total = total + q_mul(ki, ierr);
      integ_acc = sat_word(total);
    end
    last_meas = y;
    return res;
  endfunction

  // valid stays high after acceptance so back-to-back requests need no toggle
  task automatic send_sample(input word_t r, input word_t y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    setpoint_i    <= r;
    measurement_i <= y;
    do @(posedge clk_i); while (in_stall_o);
    expected_drives.push_back(predict_drive(r, y));
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all eight registers back to back; block must be idle
  task automatic program_gains(input cfg_t c);
    word_t regs [8];
    regs[REG_PROP_GAIN]  = c.prop_gain;
    regs[REG_SP_WEIGHT]  = c.setpoint_weight;
    regs[REG_DERIV_DEC]  = c.deriv_decay;
    regs[REG_DERIV_GAIN] = c.deriv_gain;
    regs[REG_INTEG_GAIN] = c.integ_gain;
    regs[REG_OUT_OFFSET] = c.out_offset;
    regs[REG_OUT_MIN]    = c.out_min;
    regs[REG_OUT_MAX]    = c.out_max;
    for (int i = 0; i < 8; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {i[REG_IDX_W-1:0], 2'b00};
      pwdata  <= regs[i];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    gains = c;
  endtask

  function automatic word_t rand_small();
    return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;  // about +-4.0
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0:       return S32_MIN;
      1:       return S32_MAX;
      2:       return '0;
      3, 4, 5: return $urandom;
      default: return rand_small();
    endcase
  endfunction

  function automatic cfg_t rand_gains();
    cfg_t  c;
    word_t a, z;
    c.prop_gain       = rand_word();
    c.setpoint_weight = rand_word();
    c.deriv_decay     = rand_word();
    c.deriv_gain      = rand_word();
    c.integ_gain      = ($urandom_range(0, 4) == 0) ? word_t'(0) : rand_word();
    c.out_offset      = rand_word();
    a = $signed($urandom_range(0, 32'h100000));
    z = -$signed($urandom_range(0, 32'h100000));
    case ($urandom_range(0, 3))
      0: begin
        c.out_min = S32_MIN;
        c.out_max = S32_MAX;
      end
      1: begin
        c.out_min = z;
        c.out_max = a;
      end
      2: begin                 // inverted limits
        c.out_min = a;
        c.out_max = z;
      end
      default: begin
        c.out_min = rand_word();
        c.out_max = rand_word();
      end
    endcase
    return c;
  endfunction

  task automatic test_reset_defaults();
    send_sample('0, '0);
    send_sample(S32_MAX, S32_MIN);
    send_sample(S32_MIN, S32_MAX);
    send_sample(-1, -1);
    send_sample(S32_MAX, S32_MAX);
    send_sample(1, '0);
    drain_requests();
  endtask

  // P = 0.5*r - y plus offset 1.0; hits each bound exactly and past it
  task automatic test_clamp_limits();
    cfg_t c;
    c = '{prop_gain: 32'sh10000, setpoint_weight: 32'sh8000, deriv_decay: '0,
          deriv_gain: '0, integ_gain: '0, out_offset: 32'sh10000,
          out_min: -32'sh20000, out_max: 32'sh30000};
    program_gains(c);
    send_sample('0, -32'sh20000);
    send_sample('0, 32'sh30000);
    send_sample('0, 32'sh40000);
    send_sample('0, -32'sh40000);
    drain_requests();
    c.out_min = 32'sh10000;
    c.out_max = -32'sh10000;
    program_gains(c);
    send_sample('0, '0);
    send_sample('0, 32'sh50000);
    drain_requests();
  endtask

  task automatic test_saturation();
    cfg_t c;
    c = '{prop_gain: S32_MAX, setpoint_weight: S32_MIN, deriv_decay: S32_MAX,
          deriv_gain: S32_MIN, integ_gain: S32_MAX, out_offset: S32_MIN,
          out_min: S32_MIN, out_max: S32_MAX};
    program_gains(c);
    send_sample(S32_MAX, S32_MIN);
    send_sample(S32_MIN, S32_MAX);
    send_sample(S32_MIN, S32_MIN);
    send_sample(S32_MAX, '0);
    send_sample('0, S32_MAX);
    send_sample(-1, 1);
    drain_requests();
  endtask

  // mostly tracking runs (held setpoint, slowly moving measurement), some noise
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
    word_t target, meas;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (3) begin
      program_gains(rand_gains());
      target = rand_small();
      meas   = rand_small();
      repeat (BLOCK_ITEMS) begin
        if ($urandom_range(0, 9) < 3) begin
          send_sample(rand_word(), rand_word());
        end else begin
          if ($urandom_range(0, 19) == 0) target = rand_small();
          meas = meas + ($signed($urandom_range(0, 32'h2000)) - 32'sh1000);
          send_sample(target, meas);
        end
      end
      drain_requests();
    end
  endtask

  // result side held off while requests keep coming; input must stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on <= 1'b0;
      end
    join_none
    repeat (12) send_sample(rand_small(), rand_small());
    drain_requests();
  endtask

  initial begin
    gains = '{prop_gain: 32'sh10000, setpoint_weight: 32'sh10000, deriv_decay: '0,
              deriv_gain: '0, integ_gain: '0, out_offset: '0,
              out_min: S32_MIN, out_max: S32_MAX};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_clamp_limits();
    test_saturation();
    test_random_traffic(24, 58);
    test_random_traffic(58, 24);
    test_random_traffic(0, 0);
    test_backpressure();

    drain_requests();
    if (mismatch_count == 0 && expected_drives.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
